FILE: hw/rtl/hsv_to_rgb_convert_core_assert.svh
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERT_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds at every edge out of reset.
`define H2R_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("h2r assertion failed");
// Antecedent implies consequent in the same cycle.
`define H2R_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("h2r assertion failed");
// Antecedent implies consequent in the next cycle.
`define H2R_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("h2r assertion failed");
`else
`define H2R_ASSERT_ALWAYS(lbl, cond)
`define H2R_ASSERT_IMPLY(lbl, ante, cons)
`define H2R_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/h2r_pkg.sv
// Shared types, constants and helpers of the HSV to RGB converter.
package h2r_pkg;

	localparam int HUE_W = 15;
	localparam int CFG_W = 9;
	localparam int CH_W  = 8;
	localparam int REG_IDX_W = 1;

	localparam logic [CFG_W-1:0] UNIT = 9'd256;

	// floor(a/15) for a below 2^12 by reciprocal multiply
	localparam logic [15:0] DIV15_MUL = 16'd34953;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SATURATION = 1'b0,
		REG_BRIGHTNESS = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

	typedef struct packed {
		logic [CFG_W-1:0] sat;
		logic [CFG_W-1:0] val;
		logic [CH_W-1:0]  c_byte;
		logic [CH_W-1:0]  z_byte;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [8:0] div15(input logic [11:0] a);
		logic [27:0] prod;
		prod = 28'(a) * 28'(DIV15_MUL);
		return prod[27:19];
	endfunction

endpackage

FILE: hw/rtl/h2r_front.sv
// Front end: accepts hues, finds the sector and the distance from its pair's centre.
module h2r_front #(
	parameter int HUE_FRAC_BITS = 6,
	localparam int P = 60 << HUE_FRAC_BITS,
	localparam int DW = $clog2(P + 1),
	localparam int ITEM_W = 3 + DW
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [h2r_pkg::HUE_W-1:0] hue,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [ITEM_W-1:0]       q_item
);

	localparam int TWO_P = 2 * P;

	logic                      adv;
	logic                      v_s1, v_s2;
	logic [h2r_pkg::HUE_W-1:0] h_s1, h_s2;
	h2r_pkg::sector_t          sec_s2;
	logic [8:0]                qt_s2;
	logic [2:0]                cnt_c;
	logic [h2r_pkg::HUE_W-1:0] t_c;
	logic [16:0]               te_c, pe_c;
	logic [DW-1:0]             d_c;

	// advance unless the last stage holds an item the queue cannot take
	assign adv      = !(v_s2 && q_full);
	assign in_ready = adv;
	assign q_push   = v_s2 && !q_full;

	always_comb begin
		cnt_c = 3'd0;
		for (int k = 1; k <= 5; k++) begin
			if (20'(h_s1) >= 20'(k * P)) begin
				cnt_c = cnt_c + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s1   <= hue;
			h_s2   <= h_s1;
			sec_s2 <= h2r_pkg::sector_t'(cnt_c);
			// hue divided by two sectors: shift out 8<<F, then divide by 15
			qt_s2  <= h2r_pkg::div15(12'(h_s1 >> (HUE_FRAC_BITS + 3)));
		end
	end

	always_comb begin
		t_c  = h_s2 - h2r_pkg::HUE_W'(32'(qt_s2) * TWO_P);
		te_c = 17'(t_c);
		pe_c = 17'(P);
		d_c  = DW'((te_c >= pe_c) ? (te_c - pe_c) : (pe_c - te_c));
	end

	assign q_item = {sec_s2, d_c};

endmodule

FILE: hw/rtl/h2r_queue.sv
// Short item queue between the front end and the arithmetic back end.
module h2r_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     wr_item,
	input  logic             pop,
	output logic [W-1:0]     rd_item,
	output h2r_pkg::q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_item    = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

FILE: hw/rtl/h2r_back.sv
// Back end: scales the secondary component and assigns channels by sector.
module h2r_back #(
	parameter int HUE_FRAC_BITS = 6,
	localparam int P = 60 << HUE_FRAC_BITS,
	localparam int DW = $clog2(P + 1),
	localparam int ITEM_W = 3 + DW
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ITEM_W-1:0]        q_item,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  h2r_pkg::cfg_t            cfg,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [h2r_pkg::CH_W-1:0] red,
	output logic [h2r_pkg::CH_W-1:0] green,
	output logic [h2r_pkg::CH_W-1:0] blue
);

	localparam int SDW = h2r_pkg::CFG_W + DW;
	localparam int QW  = $clog2(256 * P + 1);
	localparam int VQW = h2r_pkg::CFG_W + QW;
	localparam int XW  = VQW + 8;
	localparam int Y_LSB = 18 + HUE_FRAC_BITS;

	logic                      adv;
	logic                      v_b1, v_b2, v_b3, v_b4;
	h2r_pkg::sector_t          sec_in, sec_b1, sec_b2, sec_b3;
	logic [DW-1:0]             d_in;
	logic [SDW-1:0]            sd_b1;
	logic [QW-1:0]             q_c;
	logic [VQW-1:0]            vq_b2;
	logic [XW-1:0]             x_c;
	logic [11:0]               y_b3;
	logic [8:0]                xq_c;
	logic [h2r_pkg::CH_W-1:0]  xb_c, c_b, z_b;
	logic [h2r_pkg::CH_W-1:0]  r_c, g_c, b_c;

	assign adv       = !v_b4 || out_ready;
	assign q_pop     = adv && !q_empty;
	assign out_valid = v_b4;
	assign sec_in    = h2r_pkg::sector_t'(q_item[ITEM_W-1 -: 3]);
	assign d_in      = q_item[DW-1:0];

	// numerator 256*P - s*d, times v, times 255, over 65536*P
	assign q_c = QW'(256 * P) - QW'(sd_b1);
	assign x_c = {vq_b2, 8'b0} - XW'(vq_b2);

	always_comb begin
		xq_c = h2r_pkg::div15(y_b3);
		xb_c = (xq_c > 9'd255) ? 8'hFF : xq_c[7:0];
		c_b  = cfg.c_byte;
		z_b  = cfg.z_byte;
		case (sec_b3)
			h2r_pkg::SEC_R_TO_Y: begin r_c = c_b;  g_c = xb_c; b_c = z_b;  end
			h2r_pkg::SEC_Y_TO_G: begin r_c = xb_c; g_c = c_b;  b_c = z_b;  end
			h2r_pkg::SEC_G_TO_C: begin r_c = z_b;  g_c = c_b;  b_c = xb_c; end
			h2r_pkg::SEC_C_TO_B: begin r_c = z_b;  g_c = xb_c; b_c = c_b;  end
			h2r_pkg::SEC_B_TO_M: begin r_c = xb_c; g_c = z_b;  b_c = c_b;  end
			default:             begin r_c = c_b;  g_c = z_b;  b_c = xb_c; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
		end else if (adv) begin
			v_b1 <= !q_empty;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_b1 <= sec_in;
			sd_b1  <= SDW'(cfg.sat) * SDW'(d_in);
			sec_b2 <= sec_b1;
			vq_b2  <= VQW'(cfg.val) * VQW'(q_c);
			sec_b3 <= sec_b2;
			y_b3   <= x_c[Y_LSB +: 12];
			red    <= r_c;
			green  <= g_c;
			blue   <= b_c;
		end
	end

endmodule

FILE: hw/rtl/hsv_to_rgb_convert_core.sv
// Top level of the HSV to RGB converter: configuration registers and the two halves.
//
// Input channel: hue (1/64-degree steps by default) under in_valid/in_ready.
// Output channel: red, green, blue bytes under out_valid/out_ready.
// Saturation and brightness are written through write_en/reg_index/write_data,
// index 0 and 1; values above 256 act as 256. Write them only while idle.
// Throughput: one item per clock while out_ready stays high. A two-stage front end
// finds the sector and the distance from the centre of the sector pair, then a
// four-entry queue feeds a four-stage back end (a multiplier in every stage but
// the third) ending in the output register. A stalled receiver holds the back
// end; the queue absorbs the front end until full, then in_ready drops. Reset
// empties every stage and the queue and sets both saturation and brightness
// to 1.0.
`include "hsv_to_rgb_convert_core_assert.svh"

module hsv_to_rgb_convert_core #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [h2r_pkg::HUE_W-1:0]     hue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [h2r_pkg::CH_W-1:0]      red,
	output logic [h2r_pkg::CH_W-1:0]      green,
	output logic [h2r_pkg::CH_W-1:0]      blue,
	input  logic                          write_en,
	input  logic [h2r_pkg::REG_IDX_W-1:0] reg_index,
	input  logic [h2r_pkg::CFG_W-1:0]     write_data
);

	localparam int P = 60 << HUE_FRAC_BITS;
	localparam int ITEM_W = 3 + $clog2(P + 1);

	logic [h2r_pkg::CFG_W-1:0] sat_q, val_q, wr_sat_c;
	logic [16:0]               vz_c, c255_c;
	logic [24:0]               z255_c;
	h2r_pkg::cfg_t             cfg;
	h2r_pkg::q_stat_t          q_stat;
	logic                      q_push, q_pop;
	logic [ITEM_W-1:0]         wr_item, rd_item;

	// clip to 1.0 on write
	assign wr_sat_c = (write_data > h2r_pkg::UNIT) ? h2r_pkg::UNIT : write_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= h2r_pkg::UNIT;
			val_q <= h2r_pkg::UNIT;
		end else if (write_en) begin
			case (h2r_pkg::reg_idx_t'(reg_index))
				h2r_pkg::REG_SATURATION: sat_q <= wr_sat_c;
				h2r_pkg::REG_BRIGHTNESS: val_q <= wr_sat_c;
				default: ;
			endcase
		end
	end

	// full-chroma byte is floor(v*255/256); zero-channel byte floor(v*(256-s)*255/65536)
	always_comb begin
		vz_c   = 17'(val_q) * 17'(h2r_pkg::UNIT - sat_q);
		z255_c = {vz_c, 8'b0} - 25'(vz_c);
		c255_c = {val_q, 8'b0} - 17'(val_q);
		cfg.sat    = sat_q;
		cfg.val    = val_q;
		cfg.c_byte = c255_c[15:8];
		cfg.z_byte = z255_c[23:16];
	end

	h2r_front #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hue     (hue),
		.q_full  (q_stat.full),
		.q_push  (q_push),
		.q_item  (wr_item)
	);

	h2r_queue #(
		.W    (ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_item(wr_item),
		.pop    (q_pop),
		.rd_item(rd_item),
		.stat   (q_stat)
	);

	h2r_back #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_item   (rd_item),
		.q_empty  (q_stat.empty),
		.q_pop    (q_pop),
		.cfg      (cfg),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	`H2R_ASSERT_ALWAYS(a_cfg_in_range, (sat_q <= h2r_pkg::UNIT) && (val_q <= h2r_pkg::UNIT))
	`H2R_ASSERT_ALWAYS(a_chroma_over_floor, cfg.c_byte >= cfg.z_byte)
	`H2R_ASSERT_IMPLY(a_stall_only_on_full, !in_ready, q_stat.full)
	`H2R_ASSERT_NEXT(a_pop_needs_item, q_pop, !($past(q_stat.empty)))

endmodule
